// ----- hw/rtl/b2b_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLAKE2b package
// Shared constants, the message schedule table and the IV table.
// ----------------------------------------------------------------------------
package b2b_pkg;

  localparam int unsigned DefaultDigestLength = 64;
  localparam int unsigned BlockBytes = 128;
  localparam int unsigned Rounds = 12;

  // Initial chaining value.
  function automatic logic [63:0] iv_word(input logic [2:0] idx);
    logic [63:0] w;
    case (idx)
      3'd0: w = 64'h6a09e667f3bcc908;
      3'd1: w = 64'hbb67ae8584caa73b;
      3'd2: w = 64'h3c6ef372fe94f82b;
      3'd3: w = 64'ha54ff53a5f1d36f1;
      3'd4: w = 64'h510e527fade682d1;
      3'd5: w = 64'h9b05688c2b3e6c1f;
      3'd6: w = 64'h1f83d9abfb41bd6b;
      default: w = 64'h5be0cd19137e2179;
    endcase
    return w;
  endfunction

  // Message word permutation, indexed by round modulo ten and slot.
  function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] slot);
    logic [63:0] row;
    case (rnd)
      4'd0: row = 64'hfedcba9876543210;
      4'd1: row = 64'h357b20c16df984ae;
      4'd2: row = 64'h491763eadf250c8b;
      4'd3: row = 64'h8f04a562ebcd1397;
      4'd4: row = 64'hd386cb1efa427509;
      4'd5: row = 64'h91ef57d438b0a6c2;
      4'd6: row = 64'hb8293670a4def15c;
      4'd7: row = 64'ha2684f05931ce7bd;
      4'd8: row = 64'h5a417d2c803b9ef6;
      default: row = 64'h0dc3e9bf5167482a;
    endcase
    return row[slot*4 +: 4];
  endfunction

endpackage

// ----- hw/rtl/b2b_gunit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLAKE2b half-G unit
// One half of the G function: two adds, one xor-rotate, one add, one
// xor-rotate. The rotation pair is chosen by the half select.
// ----------------------------------------------------------------------------
module b2b_gunit (
  input  logic        second_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [63:0] c_i,
  input  logic [63:0] d_i,
  input  logic [63:0] m_i,
  output logic [63:0] a_o,
  output logic [63:0] b_o,
  output logic [63:0] c_o,
  output logic [63:0] d_o
);

  logic [63:0] dx, bx;

  // Rotations are 32 and 24 in the first half, 16 and 63 in the second.
  always_comb begin
    a_o = a_i + b_i + m_i;
    dx  = d_i ^ a_o;
    d_o = second_i ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
    c_o = c_i + d_o;
    bx  = b_i ^ c_o;
    b_o = second_i ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
  end

endmodule

// ----- hw/rtl/blake2b_stream_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLAKE2b stream hash
// Unkeyed BLAKE2b over a byte stream with a digest word output channel.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one word per handshake: a byte, a present
// flag and a last flag. A byte is taken per handshake into the 128-byte
// buffer unless it is full, when the pending block is compressed first. A
// compression runs 12 rounds of 8 G functions on one shared half-G unit,
// two halves per G, between a setup and a finish state. The last word
// compresses the padded block and then emits ceil(length/8) digest words,
// one per cycle when the receiver takes them; a stalled receiver holds the
// current word and the block waits.
// A last byte that lands on a full buffer costs two compressions back to back.
// in_ready_o is low during compression and output.
// Reset sets the digest length to DigestReset (64 by default) and readies a fresh message.
// A digest length write is picked up at once when no byte has been taken,
// otherwise at the next message. 0 acts as 1 and values above 64 as 64.
// ----------------------------------------------------------------------------
module blake2b_stream_hash #(
  parameter int unsigned DigestReset = b2b_pkg::DefaultDigestLength
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic [3:0]  valid_bytes_o,
  output logic        last_word_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StInit = 3'd1;
  localparam logic [2:0] StMix  = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]   state_q, state_d;
  logic [6:0]   dlen_q, alen_q;
  logic [63:0]  h_q [8];
  logic [63:0]  v_q [16];
  logic [127:0] cnt_q;
  logic [7:0]   fill_q;
  logic [63:0]  mem_q [16];
  logic [3:0]   rnd_q;
  logic [2:0]   gi_q;
  logic         half_q, final_q, pend_q, pend_last_q;
  logic [2:0]   widx_q;
  logic [6:0]   alen_new;
  logic [7:0]   pend_byte_q;

  // Clamp the register to 1..64.
  always_comb begin
    if (dlen_q == 7'd0) alen_new = 7'd1;
    else if (dlen_q > 7'd64) alen_new = 7'd64;
    else alen_new = dlen_q;
  end

  // Message word fetch from the buffer, zero past the fill.
  logic [3:0] rmod, slot, mw;
  logic [63:0] mword;
  always_comb begin
    rmod = (rnd_q >= 4'd10) ? rnd_q - 4'd10 : rnd_q;
    slot = {gi_q, half_q};
    mw = b2b_pkg::sigma(rmod, slot);
    for (int j = 0; j < 8; j++) begin
      mword[j*8 +: 8] = ({1'b0, mw, 3'(j)} < fill_q) ? mem_q[mw][j*8 +: 8] : 8'd0;
    end
  end

  // G index selection: columns then diagonals.
  logic [3:0] ia, ib, ic, id;
  always_comb begin
    case (gi_q)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
  end

  logic [63:0] ga, gb, gc, gd;
  b2b_gunit u_gunit (
    .second_i(half_q),
    .a_i(v_q[ia]), .b_i(v_q[ib]), .c_i(v_q[ic]), .d_i(v_q[id]),
    .m_i(mword),
    .a_o(ga), .b_o(gb), .c_o(gc), .d_o(gd)
  );

  logic in_fire, out_fire, full;
  assign in_ready_o = (state_q == StIdle);
  assign in_fire = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign out_fire = out_valid_o && out_ready_i;
  assign full = (fill_q == 8'(b2b_pkg::BlockBytes));

  // Output word formatting.
  logic [6:0] rem;
  logic [3:0] nb;
  logic [2:0] nwords_m1;
  always_comb begin
    rem = alen_q - {1'b0, widx_q, 3'd0};
    nb = (rem > 7'd8) ? 4'd8 : rem[3:0];
    nwords_m1 = 3'((alen_q - 7'd1) >> 3);
    for (int j = 0; j < 8; j++) begin
      digest_word_o[j*8 +: 8] = (4'(j) < nb) ? h_q[widx_q][j*8 +: 8] : 8'd0;
    end
  end
  assign word_index_o = widx_q;
  assign valid_bytes_o = nb;
  assign last_word_o = (widx_q == nwords_m1);

  // Next state. A last byte held back behind a full block runs a second,
  // final compression straight after the first.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_fire && ((byte_present_i && full) || last_byte_i)) state_d = StInit;
      StInit: state_d = StMix;
      StMix:  if (half_q && gi_q == 3'd7 && rnd_q == 4'(b2b_pkg::Rounds - 1)) state_d = StFin;
      StFin: begin
        if (final_q) state_d = StOut;
        else if (pend_q && pend_last_q) state_d = StInit;
        else state_d = StIdle;
      end
      StOut:  if (out_fire && last_word_o) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Buffer writes, one byte lane of a message word at a time.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_fire && byte_present_i && !full)
      mem_q[fill_q[6:3]][{fill_q[2:0], 3'b000} +: 8] <= data_byte_i;
    else if (state_q == StFin && pend_q)
      mem_q[0][7:0] <= pend_byte_q;
  end

  // Control and working state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dlen_q <= 7'(DigestReset);
      alen_q <= 7'(DigestReset);
      for (int i = 1; i < 8; i++) h_q[i] <= b2b_pkg::iv_word(3'(i));
      h_q[0] <= b2b_pkg::iv_word(3'd0) ^ 64'h01010000 ^ 64'(DigestReset);
      cnt_q <= '0;
      fill_q <= '0;
      rnd_q <= '0;
      gi_q <= '0;
      half_q <= 1'b0;
      final_q <= 1'b0;
      pend_q <= 1'b0;
      pend_last_q <= 1'b0;
      widx_q <= '0;
      pend_byte_q <= '0;
      for (int i = 0; i < 16; i++) v_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        dlen_q <= cfg_wdata_i;
      end
      // A fresh message picks up a new length.
      if (state_q == StIdle && fill_q == 8'd0 && cnt_q == '0 &&
          alen_q != alen_new) begin
        alen_q <= alen_new;
        h_q[0] <= b2b_pkg::iv_word(3'd0) ^ 64'h01010000 ^ 64'(alen_new);
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (byte_present_i && full) begin
              cnt_q <= cnt_q + 128'(b2b_pkg::BlockBytes);
              final_q <= 1'b0;
              pend_q <= 1'b1;
              pend_last_q <= last_byte_i;
              pend_byte_q <= data_byte_i;
            end else begin
              if (byte_present_i) fill_q <= fill_q + 8'd1;
              if (last_byte_i) begin
                cnt_q <= cnt_q + 128'(fill_q + 8'(byte_present_i));
                final_q <= 1'b1;
                pend_q <= 1'b0;
              end
            end
          end
        end
        StInit: begin
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          for (int i = 0; i < 4; i++) v_q[i+8] <= b2b_pkg::iv_word(3'(i));
          v_q[12] <= b2b_pkg::iv_word(3'd4) ^ cnt_q[63:0];
          v_q[13] <= b2b_pkg::iv_word(3'd5) ^ cnt_q[127:64];
          v_q[14] <= b2b_pkg::iv_word(3'd6) ^ {64{final_q}};
          v_q[15] <= b2b_pkg::iv_word(3'd7);
          rnd_q <= '0;
          gi_q <= '0;
          half_q <= 1'b0;
        end
        StMix: begin
          v_q[ia] <= ga;
          v_q[ib] <= gb;
          v_q[ic] <= gc;
          v_q[id] <= gd;
          half_q <= ~half_q;
          if (half_q) begin
            gi_q <= gi_q + 3'd1;
            if (gi_q == 3'd7) rnd_q <= rnd_q + 4'd1;
          end
        end
        StFin: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
          widx_q <= '0;
          if (pend_q) begin
            fill_q <= 8'd1;
            pend_q <= 1'b0;
            // The held byte also ended the message: count it and go final.
            if (pend_last_q) begin
              cnt_q <= cnt_q + 128'd1;
              final_q <= 1'b1;
              pend_last_q <= 1'b0;
            end
          end
        end
        StOut: begin
          if (out_fire) begin
            widx_q <= widx_q + 3'd1;
            if (last_word_o) begin
              alen_q <= alen_new;
              for (int i = 1; i < 8; i++) h_q[i] <= b2b_pkg::iv_word(3'(i));
              h_q[0] <= b2b_pkg::iv_word(3'd0) ^ 64'h01010000 ^ 64'(alen_new);
              cnt_q <= '0;
              fill_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
